>>> hdl/three_axis_warmup_averaging_filter_defines.svh
// Assertion macros used by the filter top level
`ifndef THREE_AXIS_WARMUP_AVERAGING_FILTER_DEFINES_SVH
`define THREE_AXIS_WARMUP_AVERAGING_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TWAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TWAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/twaf_pkg.sv
package twaf_pkg;

    // Filter dimensions
    localparam int WINDOW     = 64;
    localparam int DATA_W     = 32;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int CNT_W      = 7;

    // Serial divider: quotient bits resolved per cycle and cycle count
    localparam int STEP_BITS  = 6;
    localparam int NUM_STEPS  = (DIFF_W + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W      = NUM_STEPS * STEP_BITS;
    localparam int STEP_CNT_W = $clog2(NUM_STEPS);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_COMMIT
    } t_state;

    // Per-lane control from the sequencer
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_lane_ctrl;

endpackage

>>> hdl/twaf_lane.sv
module twaf_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  twaf_pkg::t_lane_ctrl                i_ctrl,
    input  logic signed [twaf_pkg::DATA_W-1:0]  i_sample,
    input  logic        [twaf_pkg::CNT_W-1:0]   i_divisor,
    output logic signed [twaf_pkg::DATA_W-1:0]  o_result
);
    import twaf_pkg::*;

    logic signed [DATA_W-1:0] r_filter;
    logic                     r_neg;
    logic [DIV_W-1:0]         r_shift;
    logic [CNT_W-1:0]         r_rem;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [DIV_W-1:0]         n_shift;
    logic [CNT_W-1:0]         n_rem;
    logic [DIFF_W:0]          quo_signed;
    logic [DIFF_W:0]          sum;

    // Exact difference Z - F and its magnitude
    always_comb begin
        diff = DIFF_W'($signed({i_sample[DATA_W-1], i_sample})
             - $signed({r_filter[DATA_W-1], r_filter}));
        mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    end

    // Restoring division, STEP_BITS quotient bits per cycle while i_ctrl.step is high
    always_comb begin
        logic [CNT_W:0] part;
        logic           qbit;
        n_shift = r_shift;
        n_rem   = r_rem;
        for (int b = 0; b < STEP_BITS; b++) begin
            part = {n_rem, n_shift[DIV_W-1]};
            qbit = (part >= {1'b0, i_divisor});
            if (qbit) begin
                part = part - {1'b0, i_divisor};
            end
            n_rem   = part[CNT_W-1:0];
            n_shift = {n_shift[DIV_W-2:0], qbit};
        end
    end

    // Restore sign (truncation toward zero) and add to the filter value
    always_comb begin
        quo_signed = r_neg ? (DIFF_W+1)'(-{1'b0, r_shift[DIFF_W-1:0]})
                           : {1'b0, r_shift[DIFF_W-1:0]};
        sum        = {{2{r_filter[DATA_W-1]}}, r_filter} + quo_signed;
        o_result   = sum[DATA_W-1:0];
    end

    // Filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= '0;
        end else if (i_ctrl.commit) begin
            r_filter <= o_result;
        end
    end

    // Divider datapath
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_neg   <= diff[DIFF_W-1];
            r_shift <= DIV_W'(mag);
            r_rem   <= '0;
        end else if (i_ctrl.step) begin
            r_shift <= n_shift;
            r_rem   <= n_rem;
        end
    end

endmodule

>>> hdl/twaf_merge.sv
module twaf_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_commit,
    input  logic signed [twaf_pkg::DATA_W-1:0]  i_lane_x,
    input  logic signed [twaf_pkg::DATA_W-1:0]  i_lane_y,
    input  logic signed [twaf_pkg::DATA_W-1:0]  i_lane_z,
    input  logic                                i_settled,
    output logic                                o_free,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [twaf_pkg::DATA_W-1:0]  o_filtered_x,
    output logic signed [twaf_pkg::DATA_W-1:0]  o_filtered_y,
    output logic signed [twaf_pkg::DATA_W-1:0]  o_filtered_z,
    output logic                                o_settled
);
    import twaf_pkg::*;

    logic r_valid;

    // Slot is free when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_commit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload, combining the three lanes
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            o_filtered_x <= i_lane_x;
            o_filtered_y <= i_lane_y;
            o_filtered_z <= i_lane_z;
            o_settled    <= i_settled;
        end
    end

endmodule

>>> hdl/three_axis_warmup_averaging_filter.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+----------------------------------
// sample   | i_in_valid / o_in_ready     | i_accel_x, i_accel_y, i_accel_z
// result   | o_out_valid / i_out_ready   | o_filtered_x/y/z, o_settled
//
// A transaction loads the differences, runs 6 divider steps (6 quotient
// bits each) in the per-axis lanes, then commits.
// Reset is synchronous, active low; filters and sample count clear to zero.
// A new sample is taken while a result still waits in the output register;
// the commit cycle stalls until that register is free.
`include "three_axis_warmup_averaging_filter_defines.svh"

module three_axis_warmup_averaging_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [twaf_pkg::DATA_W-1:0]  i_accel_x,
    input  logic signed [twaf_pkg::DATA_W-1:0]  i_accel_y,
    input  logic signed [twaf_pkg::DATA_W-1:0]  i_accel_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [twaf_pkg::DATA_W-1:0]  o_filtered_x,
    output logic signed [twaf_pkg::DATA_W-1:0]  o_filtered_y,
    output logic signed [twaf_pkg::DATA_W-1:0]  o_filtered_z,
    output logic                                o_settled
);
    import twaf_pkg::*;

    t_state                r_state, n_state;
    logic [STEP_CNT_W-1:0] r_step_cnt;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    t_lane_ctrl            ctrl;
    logic                  accept;
    logic                  out_free;
    logic signed [DATA_W-1:0] lane_x, lane_y, lane_z;

    assign accept = i_in_valid && o_in_ready;

    // Saturating sample count; the new count is also the divisor
    assign n_count = (r_count >= CNT_W'(WINDOW)) ? CNT_W'(WINDOW) : r_count + 1'b1;

    // Sequencer next state and lane control
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        ctrl        = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ctrl.load  = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                ctrl.step = 1'b1;
                if (r_step_cnt == STEP_CNT_W'(NUM_STEPS - 1)) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                ctrl.commit = out_free;
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cnt <= '0;
        end else if (ctrl.load) begin
            r_step_cnt <= '0;
        end else if (ctrl.step) begin
            r_step_cnt <= r_step_cnt + 1'b1;
        end
    end

    // Sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // One lane per axis
    twaf_lane u_lane_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_sample  (i_accel_x),
        .i_divisor (r_count),
        .o_result  (lane_x)
    );

    twaf_lane u_lane_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_sample  (i_accel_y),
        .i_divisor (r_count),
        .o_result  (lane_y)
    );

    twaf_lane u_lane_z (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_sample  (i_accel_z),
        .i_divisor (r_count),
        .o_result  (lane_z)
    );

    // Merge lanes into the output register
    twaf_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (ctrl.commit),
        .i_lane_x     (lane_x),
        .i_lane_y     (lane_y),
        .i_lane_z     (lane_z),
        .i_settled    (r_count == CNT_W'(WINDOW)),
        .o_free       (out_free),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_filtered_x (o_filtered_x),
        .o_filtered_y (o_filtered_y),
        .o_filtered_z (o_filtered_z),
        .o_settled    (o_settled)
    );

    // Checks
    `TWAF_ASSERT_NXT(a_accept_starts_divide, i_clk, i_rst_n, accept, (r_state == ST_DIVIDE) && (r_step_cnt == '0), "accepted sample did not start the divider")
    `TWAF_ASSERT_IMP(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(WINDOW), "sample count above window")
    `TWAF_ASSERT_NXT(a_commit_fills_output, i_clk, i_rst_n, ctrl.commit, o_out_valid && (o_settled == (r_count == CNT_W'(WINDOW))), "commit did not load the output register")

endmodule
